// ----- hdl/mac_learning_table_with_aging_macros.svh -----
// assertion macros for the mac learning table
`ifndef MAC_LEARNING_TABLE_WITH_AGING_MACROS_SVH
`define MAC_LEARNING_TABLE_WITH_AGING_MACROS_SVH

`ifndef SYNTHESIS

`define MLT_ASSERT(label, c, r, prop, msg) \
    label: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);

`define MLT_ASSERT_NEXT(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);

`else

`define MLT_ASSERT(label, c, r, prop, msg)

`define MLT_ASSERT_NEXT(label, c, r, ante, cons, msg)

`endif

`endif

// ----- hdl/mlt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mlt_pkg;

    localparam int MLT_ENTRIES = 64;
    localparam logic [31:0] AGE_LIMIT_RESET = 32'd300;

    localparam logic [2:0] OP_LOOKUP  = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_DELETE  = 3'd2;
    localparam logic [2:0] OP_DISCARD = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [47:0] mac_address;
        logic [7:0]  port_number;
    } op_item_t;

    typedef struct packed {
        logic [7:0] found_port;
        logic       success;
        logic [6:0] removed_count;
        logic       table_full;
    } result_t;

    // token walking the cell row
    typedef struct packed {
        logic [2:0]  op;
        logic [47:0] mac;
        logic [7:0]  port;
        logic        hit;
        logic [7:0]  found;
        logic        success;
        logic [6:0]  count;
        logic        claim;
    } tok_t;

endpackage

`default_nettype wire

// ----- hdl/mlt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "mac_learning_table_with_aging_macros.svh"

module mlt_cell (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [31:0]  time_now,
    input  wire logic [31:0]  age_limit,
    input  wire logic         in_valid,
    input  wire mlt_pkg::tok_t in_tok,
    output logic              out_valid,
    output mlt_pkg::tok_t     out_tok
);
    import mlt_pkg::*;

    logic        valid_reg, valid_next;
    logic [47:0] mac_reg, mac_next;
    logic [7:0]  port_reg, port_next;
    logic [31:0] seen_reg, seen_next;
    logic        tok_valid_reg;
    tok_t        tok_reg, tok_next;

    logic        match;
    logic [31:0] age;

    assign match = valid_reg && (mac_reg == in_tok.mac);
    assign age   = time_now - seen_reg;

    always_comb
    begin
        valid_next = valid_reg;
        mac_next   = mac_reg;
        port_next  = port_reg;
        seen_next  = seen_reg;
        tok_next   = in_tok;
        if (in_valid)
        begin
            case (in_tok.op)
                OP_LOOKUP:
                begin
                    if (match && !in_tok.hit)
                    begin
                        tok_next.hit = 1'b1;
                        if (age > age_limit)
                        begin
                            valid_next = 1'b0;
                        end
                        else
                        begin
                            tok_next.found = port_reg;
                        end
                    end
                end
                OP_INSERT:
                begin
                    if (in_tok.claim)
                    begin
                        // first free cell takes the new entry
                        if (!valid_reg && !in_tok.hit)
                        begin
                            valid_next       = 1'b1;
                            mac_next         = in_tok.mac;
                            port_next        = in_tok.port;
                            seen_next        = time_now;
                            tok_next.hit     = 1'b1;
                            tok_next.success = 1'b1;
                        end
                    end
                    else if (match && !in_tok.hit)
                    begin
                        seen_next    = time_now;
                        tok_next.hit = 1'b1;
                    end
                end
                OP_DELETE:
                begin
                    if (match && !in_tok.hit)
                    begin
                        valid_next       = 1'b0;
                        tok_next.hit     = 1'b1;
                        tok_next.success = 1'b1;
                    end
                end
                OP_DISCARD:
                begin
                    if (valid_reg && (port_reg == in_tok.port))
                    begin
                        valid_next     = 1'b0;
                        tok_next.count = in_tok.count + 7'd1;
                    end
                end
                default:
                begin
                    tok_next = in_tok;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            tok_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg  <= mac_next;
        port_reg <= port_next;
        seen_reg <= seen_next;
        tok_reg  <= tok_next;
    end

    assign out_valid = tok_valid_reg;
    assign out_tok   = tok_reg;

    `MLT_ASSERT(a_fill_only_by_claim, clk, rst_n,
        $rose(valid_reg) |-> $past(in_valid && in_tok.claim), "entry filled outside claim pass")

endmodule

`default_nettype wire

// ----- hdl/mac_learning_table_with_aging.sv -----
// channel   dir  handshake                payload
// in        in   in_valid / in_ready      in_data   (op_item_t)
// out       out  out_valid / out_ready    out_data  (result_t)
// cfg       in   cfg_valid / cfg_ready    cfg_data  (age limit, 32 bits)
//
// lookup, delete, discard and refresh: one walk along the cell row, one cell of the row per cycle
// insert of a new address: a second walk claims the first free cell
// tick and unknown operations: no walk, straight to the finish state
// one operation at a time; in_ready is low until its result sits in the output register
// reset clears every valid bit at once, no clearing pass; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none
`include "mac_learning_table_with_aging_macros.svh"

module mac_learning_table_with_aging #(
    parameter int ENTRIES = mlt_pkg::MLT_ENTRIES
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mlt_pkg::op_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mlt_pkg::result_t       out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [31:0]       cfg_data
);
    import mlt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [31:0] time_reg, time_next;
    logic [31:0] limit_reg, limit_next;
    result_t     res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic        head_valid;
    tok_t        head_tok;
    logic [ENTRIES-1:0] chain_valid;
    tok_t        chain_tok [ENTRIES];
    logic        tail_valid;
    tok_t        tail_tok;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                mlt_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .time_now  (time_reg),
                    .age_limit (limit_reg),
                    .in_valid  (head_valid),
                    .in_tok    (head_tok),
                    .out_valid (chain_valid[g]),
                    .out_tok   (chain_tok[g])
                );
            end
            else
            begin : g_body
                mlt_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .time_now  (time_reg),
                    .age_limit (limit_reg),
                    .in_valid  (chain_valid[g-1]),
                    .in_tok    (chain_tok[g-1]),
                    .out_valid (chain_valid[g]),
                    .out_tok   (chain_tok[g])
                );
            end
        end
    endgenerate

    assign tail_valid = chain_valid[ENTRIES-1];
    assign tail_tok   = chain_tok[ENTRIES-1];

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        limit_next     = limit_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        head_valid     = 1'b0;
        head_tok       = '0;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    head_tok.op   = in_data.operation;
                    head_tok.mac  = in_data.mac_address;
                    head_tok.port = in_data.port_number;
                    case (in_data.operation)
                        OP_LOOKUP, OP_INSERT, OP_DELETE, OP_DISCARD:
                        begin
                            head_valid = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        OP_TICK:
                        begin
                            time_next  = time_reg + 32'd1;
                            res_next   = '0;
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (tail_valid)
                begin
                    if ((tail_tok.op == OP_INSERT) && !tail_tok.claim && !tail_tok.hit)
                    begin
                        // no entry holds the address, walk again to claim a free one
                        head_valid     = 1'b1;
                        head_tok       = tail_tok;
                        head_tok.claim = 1'b1;
                    end
                    else
                    begin
                        res_next.found_port    = tail_tok.found;
                        res_next.success       = tail_tok.success;
                        res_next.removed_count = tail_tok.count;
                        res_next.table_full    = (tail_tok.op == OP_INSERT) &&
                                                 tail_tok.claim && !tail_tok.hit;
                        state_next             = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            time_reg      <= '0;
            limit_reg     <= AGE_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    `MLT_ASSERT(a_one_token, clk, rst_n,
        ($countones(chain_valid) <= 1) && (!(|chain_valid) || (state_reg == ST_SWEEP)),
        "more than one token in the cell row")
    `MLT_ASSERT(a_count_discard_only, clk, rst_n,
        (tail_valid && (tail_tok.op != OP_DISCARD)) |-> (tail_tok.count == 7'd0),
        "removal count from an operation other than discard")
    `MLT_ASSERT(a_port_lookup_only, clk, rst_n,
        (tail_valid && (tail_tok.op != OP_LOOKUP)) |-> (tail_tok.found == 8'd0),
        "found port from an operation other than lookup")

endmodule

`default_nettype wire

// ----- verif/mac_learning_table_with_aging_tb.sv -----
`timescale 1ns / 1ps

module mac_learning_table_with_aging_tb;
    import mlt_pkg::*;

    localparam int FDB_ENTRIES = MLT_ENTRIES;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 2 * FDB_ENTRIES + 8;
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_MID = 3'd6;
    localparam logic [2:0] OP_RSVD_LAST = 3'd7;
    localparam logic [47:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] MAC_ZERO = 48'h0;
    localparam logic [31:0] AGE_NEVER = 32'hFFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    op_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    result_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] cfg_data = '0;

    // predicted table contents
    logic [31:0] fdb_age_limit = AGE_LIMIT_RESET;
    logic [31:0] fdb_now = '0;
    logic fdb_valid [0:FDB_ENTRIES-1];
    logic [47:0] fdb_mac [0:FDB_ENTRIES-1];
    logic [7:0] fdb_port [0:FDB_ENTRIES-1];
    logic [31:0] fdb_seen [0:FDB_ENTRIES-1];

    result_t fdb_expected [$];
    logic [47:0] mac_pool [0:127];
    int error_count = 0;
    int idle_pct = 10;
    int cycle_count = 0;

    mac_learning_table_with_aging u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int fdb_find(logic [47:0] mac);
        int i;
        for (i = 0; i < FDB_ENTRIES; i++)
        begin
            if (fdb_valid[i] && fdb_mac[i] == mac)
                return i;
        end
        return -1;
    endfunction

    function automatic result_t fdb_apply(op_item_t it);
        result_t r;
        int hit;
        int i;
        int removed;
        logic [31:0] age;
        r = '0;
        removed = 0;
        hit = fdb_find(it.mac_address);
        case (it.operation)
            OP_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    age = fdb_now - fdb_seen[hit];
                    if (age > fdb_age_limit)
                        fdb_valid[hit] = 1'b0;
                    else
                        r.found_port = fdb_port[hit];
                end
            end
            OP_INSERT:
            begin
                if (hit >= 0)
                    fdb_seen[hit] = fdb_now;
                else
                begin
                    i = 0;
                    while (i < FDB_ENTRIES && fdb_valid[i])
                        i++;
                    if (i < FDB_ENTRIES)
                    begin
                        fdb_valid[i] = 1'b1;
                        fdb_mac[i] = it.mac_address;
                        fdb_port[i] = it.port_number;
                        fdb_seen[i] = fdb_now;
                        r.success = 1'b1;
                    end
                    else
                        r.table_full = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (hit >= 0)
                begin
                    fdb_valid[hit] = 1'b0;
                    r.success = 1'b1;
                end
            end
            OP_DISCARD:
            begin
                for (i = 0; i < FDB_ENTRIES; i++)
                begin
                    if (fdb_valid[i] && fdb_port[i] == it.port_number)
                    begin
                        fdb_valid[i] = 1'b0;
                        removed++;
                    end
                end
                r.removed_count = 7'(removed);
            end
            OP_TICK:
                fdb_now = fdb_now + 32'd1;
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic send_op(logic [2:0] op, logic [47:0] mac, logic [7:0] port);
        op_item_t it;
        it.operation = op;
        it.mac_address = mac;
        it.port_number = port;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fdb_expected.push_back(fdb_apply(it));
    endtask

    // lower valid and wait for every outstanding result
    task automatic drain;
        in_valid <= 1'b0;
        while (fdb_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_age_limit(logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        fdb_age_limit = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(logic [31:0] age, int n, int pool_n, int port_lo, int port_hi,
                               int w_ins, int w_look, int w_del, int w_disc, int w_tick);
        int done;
        int pick;
        int i;
        logic [2:0] op;
        logic [47:0] mac;
        logic [7:0] port;
        write_age_limit(age);
        for (i = 0; i < pool_n; i++)
            mac_pool[i] = {16'($urandom), 32'($urandom)};
        done = 0;
        while (done < n)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                mac = {16'($urandom), 32'($urandom)};
            else
                mac = mac_pool[$urandom_range(0, pool_n - 1)];
            port = 8'($urandom_range(port_lo, port_hi));
            if (pick < w_ins)
                op = OP_INSERT;
            else if (pick < w_ins + w_look)
                op = OP_LOOKUP;
            else if (pick < w_ins + w_look + w_del)
                op = OP_DELETE;
            else if (pick < w_ins + w_look + w_del + w_disc)
                op = OP_DISCARD;
            else if (pick < w_ins + w_look + w_del + w_disc + w_tick)
                op = OP_TICK;
            else
                op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            send_op(op, mac, port);
            if (op < OP_RSVD_FIRST)
                done++;
        end
    endtask

    task automatic test_field_extremes;
        send_op(OP_LOOKUP, MAC_ZERO, 8'd0);
        send_op(OP_INSERT, MAC_ALL_ONES, 8'hFF);
        send_op(OP_INSERT, MAC_ZERO, 8'd0);
        send_op(OP_LOOKUP, MAC_ALL_ONES, 8'd0);
        send_op(OP_LOOKUP, MAC_ZERO, 8'hFF);
        // refresh keeps the stored port
        send_op(OP_INSERT, MAC_ALL_ONES, 8'd7);
        send_op(OP_LOOKUP, MAC_ALL_ONES, 8'd7);
        send_op(OP_DELETE, MAC_ZERO, 8'd0);
        send_op(OP_DELETE, MAC_ZERO, 8'd0);
        send_op(OP_DISCARD, MAC_ZERO, 8'hFF);
        send_op(OP_TICK, MAC_ALL_ONES, 8'hFF);
        send_op(OP_RSVD_FIRST, MAC_ALL_ONES, 8'hFF);
        send_op(OP_RSVD_MID, MAC_ZERO, 8'd0);
        send_op(OP_RSVD_LAST, MAC_ALL_ONES, 8'hFF);
    endtask

    task automatic test_aging_rules;
        write_age_limit(32'd1);
        send_op(OP_INSERT, 48'h0000_0000_00A1, 8'd3);
        send_op(OP_TICK, MAC_ZERO, 8'd0);
        send_op(OP_TICK, MAC_ZERO, 8'd0);
        // aged entry refreshed by insert
        send_op(OP_INSERT, 48'h0000_0000_00A1, 8'd3);
        send_op(OP_LOOKUP, 48'h0000_0000_00A1, 8'd0);
        send_op(OP_INSERT, 48'h0000_0000_00B2, 8'd9);
        send_op(OP_INSERT, 48'h0000_0000_00C3, 8'd9);
        send_op(OP_TICK, MAC_ZERO, 8'd0);
        send_op(OP_TICK, MAC_ZERO, 8'd0);
        send_op(OP_DELETE, 48'h0000_0000_00B2, 8'd0);
        send_op(OP_DISCARD, MAC_ZERO, 8'd9);
        send_op(OP_INSERT, 48'h0000_0000_00D4, 8'd4);
        send_op(OP_TICK, MAC_ZERO, 8'd0);
        send_op(OP_LOOKUP, 48'h0000_0000_00D4, 8'd0);
        send_op(OP_TICK, MAC_ZERO, 8'd0);
        send_op(OP_LOOKUP, 48'h0000_0000_00D4, 8'd0);
        send_op(OP_LOOKUP, 48'h0000_0000_00D4, 8'd0);
    endtask

    task automatic test_age_limit_extremes;
        run_traffic(AGE_NEVER, 340, 40, 1, 8, 35, 30, 10, 5, 15);
        run_traffic(32'd0, 340, 24, 1, 4, 35, 30, 10, 5, 15);
    endtask

    task automatic test_table_full;
        // no idling on either side for this stretch
        idle_pct = 0;
        run_traffic(32'd6, 340, 100, 1, 1, 62, 22, 4, 1, 8);
        idle_pct = 10;
    endtask

    task automatic test_random_traffic;
        run_traffic(32'($urandom_range(1, 40)), 340, 70, 0, 255, 40, 30, 10, 5, 13);
        run_traffic(32'd3, 340, 30, 250, 255, 35, 30, 10, 5, 18);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < FDB_ENTRIES; i++)
            fdb_valid[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_aging_rules();
        test_age_limit_extremes();
        test_table_full();
        test_random_traffic();
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("mac_learning_table_with_aging_tb: done, clean");
        else
            $display("mac_learning_table_with_aging_tb: done, errors");
        $finish;
    end

    // result side: random back-pressure and field compare on each transfer
    initial
    begin
        result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (fdb_expected.size() == 0)
                begin
                    $error("unexpected result transfer: %h", out_data);
                    error_count++;
                end
                else
                begin
                    exp_r = fdb_expected.pop_front();
                    if (out_data.found_port !== exp_r.found_port)
                    begin
                        $error("found_port: expected %0d, got %0d",
                               exp_r.found_port, out_data.found_port);
                        error_count++;
                    end
                    if (out_data.success !== exp_r.success)
                    begin
                        $error("success: expected %0d, got %0d",
                               exp_r.success, out_data.success);
                        error_count++;
                    end
                    if (out_data.removed_count !== exp_r.removed_count)
                    begin
                        $error("removed_count: expected %0d, got %0d",
                               exp_r.removed_count, out_data.removed_count);
                        error_count++;
                    end
                    if (out_data.table_full !== exp_r.table_full)
                    begin
                        $error("table_full: expected %0d, got %0d",
                               exp_r.table_full, out_data.table_full);
                        error_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("mac_learning_table_with_aging_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/mlt_pkg.sv
hdl/mlt_cell.sv
hdl/mac_learning_table_with_aging.sv
verif/mac_learning_table_with_aging_tb.sv
